// ===== src/tod_pkg.sv =====
// Shared types and constants for the time-of-day clock.
// Used by tod_alu and time_of_day_clock; no dependencies.
package tod_pkg;

  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned SecW  = 6;

  localparam logic [HourW-1:0] HourMax    = 5'd23;
  localparam logic [HourW-1:0] HoursDay   = 5'd24;
  localparam logic [MinW-1:0]  MinMax     = 6'd59;
  localparam logic [MinW-1:0]  SecMax     = 6'd59;
  localparam logic [MinW-1:0]  Sixty      = 6'd60;
  localparam logic [HourW-1:0] DinnerHr0  = 5'd20;
  localparam logic [HourW-1:0] DinnerHr1  = 5'd22;
  localparam logic [MinW-1:0]  DinnerMin0 = 6'd30;
  localparam logic [HourW-1:0] LateHr     = 5'd23;
  localparam logic [HourW-1:0] EarlyHr    = 5'd6;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_CMP  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ORD_LATER   = 2'd0,
    ORD_EARLIER = 2'd1,
    ORD_EQUAL   = 2'd2
  } order_e;

  typedef struct packed {
    logic [SecW-1:0]  seconds;
    logic [MinW-1:0]  minutes;
    logic [HourW-1:0] hours;
  } tod_t;

  // packed so that hours land in the lowest bits of tdata
  typedef struct packed {
    logic   late_window;
    logic   dinner_window;
    order_e order;
    tod_t   delta;
    tod_t   left;
    tod_t   cur;
  } res_t;

endpackage

// ===== src/tod_alu.sv =====
// Single-pass step logic: next stored time and the result word for one item.
// Depends on tod_pkg.
module tod_alu (
  input  tod_pkg::op_e  op_i,
  input  tod_pkg::tod_t arg_i,
  input  tod_pkg::tod_t cur_i,
  output tod_pkg::tod_t nxt_o,
  output tod_pkg::res_t res_o
);
  import tod_pkg::*;

  tod_t             q;
  tod_t             delta;
  order_e           ord;
  logic [SecW:0]    ds_raw;
  logic [MinW:0]    dm_raw;
  logic [HourW:0]   dh_raw;
  logic             bs, bm;
  logic [MinW:0]    m_adj;
  logic             ls_b, lm_b;
  tod_t             left;
  tod_t             nxt;
  logic             dinner, late;
  tod_t             out_delta;
  order_e           out_ord;

  // query fields out of range read as zero
  always_comb begin
    q.hours   = (arg_i.hours   > HourMax) ? '0 : arg_i.hours;
    q.minutes = (arg_i.minutes > MinMax)  ? '0 : arg_i.minutes;
    q.seconds = (arg_i.seconds > SecMax)  ? '0 : arg_i.seconds;
  end

  // stored minus query with borrows, mod 24 h
  always_comb begin
    ds_raw = {1'b0, cur_i.seconds} - {1'b0, q.seconds};
    bs     = ds_raw[SecW];
    dm_raw = {1'b0, cur_i.minutes} - {1'b0, q.minutes} - {{MinW{1'b0}}, bs};
    bm     = dm_raw[MinW];
    dh_raw = {1'b0, cur_i.hours} - {1'b0, q.hours} - {{HourW{1'b0}}, bm};
    delta.seconds = bs ? ds_raw[SecW-1:0] + Sixty : ds_raw[SecW-1:0];
    delta.minutes = bm ? dm_raw[MinW-1:0] + Sixty : dm_raw[MinW-1:0];
    delta.hours   = dh_raw[HourW] ? dh_raw[HourW-1:0] + HoursDay : dh_raw[HourW-1:0];
    if ({cur_i.hours, cur_i.minutes, cur_i.seconds} > {q.hours, q.minutes, q.seconds}) begin
      ord = ORD_LATER;
    end else if ({cur_i.hours, cur_i.minutes, cur_i.seconds} <
                 {q.hours, q.minutes, q.seconds}) begin
      ord = ORD_EARLIER;
    end else begin
      ord = ORD_EQUAL;
    end
  end

  always_comb begin
    nxt       = cur_i;
    out_delta = '0;
    out_ord   = ORD_EQUAL;
    case (op_i)
      OP_TICK: begin
        if (cur_i.seconds == SecMax) begin
          nxt.seconds = '0;
          if (cur_i.minutes == MinMax) begin
            nxt.minutes = '0;
            nxt.hours   = (cur_i.hours == HourMax) ? '0 : cur_i.hours + 5'd1;
          end else begin
            nxt.minutes = cur_i.minutes + 6'd1;
          end
        end else begin
          nxt.seconds = cur_i.seconds + 6'd1;
        end
      end
      OP_SET: begin
        if (arg_i.hours   <= HourMax) nxt.hours   = arg_i.hours;
        if (arg_i.minutes <= MinMax)  nxt.minutes = arg_i.minutes;
        if (arg_i.seconds <= SecMax)  nxt.seconds = arg_i.seconds;
      end
      OP_CMP: begin
        out_delta = delta;
        out_ord   = ord;
      end
      default: ;
    endcase
  end

  // 24:00:00 minus the new time; midnight itself reads as zero
  always_comb begin
    ls_b  = (nxt.seconds != '0);
    m_adj = {1'b0, nxt.minutes} + {{MinW{1'b0}}, ls_b};
    lm_b  = (m_adj != '0);
    left.seconds = ls_b ? Sixty - nxt.seconds : '0;
    left.minutes = lm_b ? Sixty - m_adj[MinW-1:0] : '0;
    left.hours   = HoursDay - nxt.hours - {{(HourW-1){1'b0}}, lm_b};
    if (nxt == '0) left = '0;
  end

  always_comb begin
    dinner = (nxt.hours >= DinnerHr0) && (nxt.hours <= DinnerHr1) &&
             !((nxt.hours == DinnerHr0) && (nxt.minutes < DinnerMin0)) &&
             !((nxt.hours == DinnerHr1) && (nxt.minutes != '0));
    late   = !((nxt.hours < LateHr) && (nxt.hours > EarlyHr)) &&
             !((nxt.hours == EarlyHr) && ((nxt.minutes != '0) || (nxt.seconds != '0)));
  end

  assign nxt_o               = nxt;
  assign res_o.cur           = nxt;
  assign res_o.left          = left;
  assign res_o.delta         = out_delta;
  assign res_o.order         = out_ord;
  assign res_o.dinner_window = dinner;
  assign res_o.late_window   = late;

endmodule

// ===== src/time_of_day_clock.sv =====
// Top level of the 24-hour time-of-day clock: input register, step logic, result register.
// Depends on tod_pkg and tod_alu.
//
// Usage:
//   Input stream: s_axis_tuser carries the opcode (tick, set, compare),
//   s_axis_tdata the hours/minutes/seconds operand. Each accepted word
//   produces exactly one result word on the m_axis stream: the time after
//   the step, time left to midnight, the compare delta and order, and the
//   dinner and late window flags.
//   Path: an accepted word sits in the input register, then the step logic
//   loads the result register once the output side can take it.
//   Throughput: one word per cycle while m_axis_tready is high; the stored time is
//   updated as a word leaves the input register, so the next word sees it with no gap.
//   Reset: the time is 00:00:00 and both stages are empty.
//   Stall: while m_axis_tready is low the result holds; one more word can
//   still be taken into the input register, after which s_axis_tready drops.
module time_of_day_clock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // arg_hours[4:0], arg_minutes[10:5], arg_seconds[16:11], 0
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // cur h/m/s [16:0], left h/m/s [33:17],
                                      // delta h/m/s [50:34], order [52:51],
                                      // dinner_window [53], late_window [54], 0
);
  import tod_pkg::*;

  logic  s1_valid_q;
  op_e   op_q;
  tod_t  arg_q;
  logic  out_valid_q;
  res_t  res_q;
  tod_t  time_q;

  tod_t  time_d;
  res_t  res_d;
  logic  out_ready;
  logic  s1_fire;
  logic  in_fire;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && out_ready;
  assign s_axis_tready = !s1_valid_q || out_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  tod_alu u_alu (
    .op_i  (op_q),
    .arg_i (arg_q),
    .cur_i (time_q),
    .nxt_o (time_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      time_q      <= '0;
    end else begin
      if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
      if (out_ready) out_valid_q <= s1_valid_q;
      if (s1_fire) time_q <= time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q          <= op_e'(s_axis_tuser);
      arg_q.hours   <= s_axis_tdata[4:0];
      arg_q.minutes <= s_axis_tdata[10:5];
      arg_q.seconds <= s_axis_tdata[16:11];
    end
    if (s1_fire) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          res_q.late_window, res_q.dinner_window, res_q.order,
                          res_q.delta.seconds, res_q.delta.minutes, res_q.delta.hours,
                          res_q.left.seconds, res_q.left.minutes, res_q.left.hours,
                          res_q.cur.seconds, res_q.cur.minutes, res_q.cur.hours};

`ifndef SYNTHESIS
  a_time_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q.hours <= HourMax) && (time_q.minutes <= MinMax) && (time_q.seconds <= SecMax))
    else $error("stored time out of range");

  a_tick_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (op_q == OP_TICK)) |=> (time_q != $past(time_q)))
    else $error("tick did not advance the time");

  a_equal_no_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.order == ORD_EQUAL)) |-> (res_q.delta == '0))
    else $error("equal order with nonzero delta");

  a_left_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_q.left == '0) == (res_q.cur == '0)))
    else $error("time left to midnight inconsistent with current time");
`endif

endmodule
